FILE: rtl/core/lsrr_pkg.sv
// Shared constants and types for the least-served round-robin arbiter.
// No dependencies; used by every file in rtl/core.
package lsrr_pkg;

	localparam int SLOTS      = 64;
	localparam int COUNT_BITS = 16;
	localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int MASK_W     = 64;  // ready_mask field width
	localparam int GSLOT_W    = 6;   // grant_slot field width
	localparam int OUT_W      = 8;   // grant_valid + grant_slot, padded to a byte

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} lsrr_state_t;

	// controls from the sequencer to the picker
	typedef struct packed {
		logic clear;
		logic step;
	} lsrr_pick_ctl_t;

	// running winner of the scan
	typedef struct packed {
		logic                 found;
		logic [SLOT_BITS-1:0] slot;
	} lsrr_pick_t;

endpackage

FILE: rtl/core/lsrr_cell.sv
// One grant-count cell of the rotating ring.
// Depends on lsrr_pkg.
module lsrr_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              shift,
	input  logic                              inc,
	input  logic [lsrr_pkg::COUNT_BITS-1:0]   count_in,
	output logic [lsrr_pkg::COUNT_BITS-1:0]   count
);

	logic [lsrr_pkg::COUNT_BITS-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (shift) begin
			count_q <= count_in;
		end else if (inc && (count_q != {lsrr_pkg::COUNT_BITS{1'b1}})) begin
			count_q <= count_q + 1'b1;  // saturates at all ones
		end
	end

	assign count = count_q;

endmodule

FILE: rtl/core/lsrr_picker.sv
// Running minimum over the scan: key is {count, distance from start slot}.
// Depends on lsrr_pkg.
module lsrr_picker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lsrr_pkg::lsrr_pick_ctl_t          ctl,
	input  logic                              ready,
	input  logic [lsrr_pkg::COUNT_BITS-1:0]   count,
	input  logic [lsrr_pkg::SLOT_BITS-1:0]    slot,
	input  logic [lsrr_pkg::SLOT_BITS-1:0]    offset,
	output lsrr_pkg::lsrr_pick_t              pick
);

	logic                             found_q;
	logic [lsrr_pkg::SLOT_BITS-1:0]   slot_q;
	logic [lsrr_pkg::SLOT_BITS-1:0]   offset_q;
	logic [lsrr_pkg::COUNT_BITS-1:0]  count_q;
	logic                             better;

	// smaller count wins; equal count goes to the slot met first from start
	assign better = ready && (!found_q || (count < count_q) ||
		((count == count_q) && (offset < offset_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (ctl.step && better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && better) begin
			slot_q   <= slot;
			offset_q <= offset;
			count_q  <= count;
		end
	end

	assign pick.found = found_q;
	assign pick.slot  = slot_q;

endmodule

FILE: rtl/core/least_served_round_robin_arbiter.sv
// Top level of the least-served round-robin arbiter: sequencer, ring of
// count cells and picker. Depends on lsrr_pkg, lsrr_cell, lsrr_picker.
//
//  channel  | dir | fields (low bit first)                     | handshake
//  ---------+-----+--------------------------------------------+-----------------
//  s_axis   | in  | tdata[63:0] ready_mask                     | s_tvalid/s_tready
//  m_axis   | out | tdata[0] grant_valid, [6:1] grant_slot,    | m_tvalid/m_tready
//           |     | [7] zero                                   |
//
// A request is accepted, then the ring rotates every count once past cell 0
// where the picker looks, then the winner's count is updated and the output
// register is loaded. The scan length is set by the ring rotating one cell per
// cycle. Reset clears all counts at once and sets the start slot to 0. A
// stalled output holds the block in its final state; the next request is
// taken as soon as the result is in the output reg.
module least_served_round_robin_arbiter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [lsrr_pkg::MASK_W-1:0]   s_tdata,   // [63:0] ready_mask
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lsrr_pkg::OUT_W-1:0]    m_tdata    // [0] grant_valid, [6:1] grant_slot
);

	localparam int N  = lsrr_pkg::SLOTS;
	localparam int SB = lsrr_pkg::SLOT_BITS;
	localparam int CB = lsrr_pkg::COUNT_BITS;

	lsrr_pkg::lsrr_state_t    state_q, state_d;
	lsrr_pkg::lsrr_pick_ctl_t pick_ctl;
	lsrr_pkg::lsrr_pick_t     pick;

	logic [N-1:0]  mask_q;       // ready bits, shifted right during the scan
	logic [SB-1:0] idx_q;        // slot currently sitting in cell 0
	logic [SB-1:0] start_q;      // first slot of the next search
	logic [SB-1:0] offset;
	logic [SB:0]   offset_wide;
	logic [SB-1:0] base_slot;
	logic          shift_en;
	logic          accept;
	logic          done_fire;
	logic          out_vld_q;
	logic [lsrr_pkg::OUT_W-1:0] out_data_q;
	logic [N-1:0]  inc_vec;
	logic [CB-1:0] count_w [N];

	assign accept = s_tvalid && s_tready;

	// ---------------- ring of count cells ----------------
	// cell k takes from cell k+1; after N shifts every count is home again
	for (genvar k = 0; k < N; k++) begin : g_cell
		lsrr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (shift_en),
			.inc      (inc_vec[k]),
			.count_in (count_w[(k + 1) % N]),
			.count    (count_w[k])
		);
	end

	// only the winning cell bumps its count, in the final cycle
	always_comb begin
		for (int k = 0; k < N; k++) begin
			inc_vec[k] = done_fire && pick.found && (pick.slot == SB'(k));
		end
	end

	// ---------------- search distance ----------------
	// (idx - start) mod N; tie-break key so the scan may run from slot 0
	always_comb begin
		if (idx_q >= start_q) begin
			offset_wide = {1'b0, idx_q} - {1'b0, start_q};
		end else begin
			offset_wide = {1'b0, idx_q} + (SB + 1)'(N) - {1'b0, start_q};
		end
	end
	assign offset = offset_wide[SB-1:0];

	lsrr_picker u_picker (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pick_ctl),
		.ready  (mask_q[0]),
		.count  (count_w[0]),
		.slot   (idx_q),
		.offset (offset),
		.pick   (pick)
	);

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			lsrr_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = lsrr_pkg::ST_SCAN;
			end
			lsrr_pkg::ST_SCAN: begin
				if (idx_q == SB'(N - 1)) state_d = lsrr_pkg::ST_DONE;
			end
			lsrr_pkg::ST_DONE: begin
				if (!out_vld_q || m_tready) state_d = lsrr_pkg::ST_IDLE;
			end
			default: state_d = lsrr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready       = 1'b0;
		shift_en       = 1'b0;
		pick_ctl.clear = 1'b0;
		pick_ctl.step  = 1'b0;
		done_fire      = 1'b0;
		case (state_q)
			lsrr_pkg::ST_IDLE: begin
				s_tready       = 1'b1;
				pick_ctl.clear = 1'b1;
			end
			lsrr_pkg::ST_SCAN: begin
				shift_en      = 1'b1;
				pick_ctl.step = 1'b1;
			end
			lsrr_pkg::ST_DONE: begin
				done_fire = !out_vld_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsrr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (accept) begin
			idx_q <= '0;
		end else if (shift_en) begin
			idx_q <= (idx_q == SB'(N - 1)) ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mask_q <= s_tdata[N-1:0];  // bits at or above SLOTS are dropped
		end else if (shift_en) begin
			mask_q <= mask_q >> 1;
		end
	end

	// pointer: granted slot, or this search's start when none was ready
	assign base_slot = pick.found ? pick.slot : start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (done_fire) begin
			start_q <= (base_slot == SB'(N - 1)) ? '0 : base_slot + 1'b1;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (done_fire) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			out_data_q <= {1'b0,
				pick.found ? lsrr_pkg::GSLOT_W'(pick.slot) : {lsrr_pkg::GSLOT_W{1'b0}},
				pick.found};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule

FILE: rtl/core/lsrr_checker.sv
// Port-level checks for the least-served round-robin arbiter, bound to the
// top level. Depends on lsrr_pkg and least_served_round_robin_arbiter.
module lsrr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [lsrr_pkg::MASK_W-1:0]   s_tdata,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [lsrr_pkg::OUT_W-1:0]    m_tdata
);

	// one request in flight: no new request the cycle after one is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while previous one in work");

	// no grant means slot field is zero
	a_no_grant_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[6:1] == 6'd0))
		else $error("nonzero slot without grant");

	// pad bit stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[7])
		else $error("pad bit set");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind least_served_round_robin_arbiter lsrr_checker u_lsrr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: test/lsrr_grant_checker.sv
// Grant checker for the least-served round-robin arbiter: watches both
// stream channels, predicts every grant and compares it with the block's result.
// Depends on lsrr_pkg for sizes; used by tb_least_served_round_robin_arbiter.
module lsrr_grant_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [lsrr_pkg::MASK_W-1:0] s_tdata,   // [63:0] ready_mask
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [lsrr_pkg::OUT_W-1:0]  m_tdata,   // [0] grant_valid, [6:1] grant_slot
	output int                          fail_count,
	output int                          outstanding
);

	import lsrr_pkg::*;

	typedef struct packed {
		logic               granted;
		logic [GSLOT_W-1:0] slot;
	} grant_t;

	logic [COUNT_BITS-1:0] served [SLOTS];
	logic [SLOT_BITS-1:0]  prev_slot;
	grant_t                grant_q [$];
	grant_t                want;
	int                    result_idx;

	task automatic report_mismatch(input string msg);
		$display("[%0t] result %0d: %s", $realtime, result_idx, msg);
		fail_count++;
	endtask

	// one decision: least-served ready slot, searching from one past the pointer
	function automatic grant_t arbitrate(input logic [MASK_W-1:0] ready);
		int     start;
		int     s;
		int     i;
		int     pick;
		grant_t g;
		start = (int'(prev_slot) + 1) % SLOTS;
		pick  = start;
		for (i = 0; i < SLOTS; i++) begin
			s = (start + i) % SLOTS;
			if (ready[s] && (!ready[pick] || served[s] < served[pick]))
				pick = s;
		end
		prev_slot = pick[SLOT_BITS-1:0];
		g = '0;
		if (ready[pick]) begin
			if (served[pick] != {COUNT_BITS{1'b1}})
				served[pick]++;
			g.granted = 1'b1;
			g.slot    = pick[GSLOT_W-1:0];
		end
		return g;
	endfunction

	initial begin
		fail_count  = 0;
		outstanding = 0;
		result_idx  = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (served[k])
				served[k] = '0;
			prev_slot = SLOT_BITS'(SLOTS - 1);
			grant_q.delete();
			outstanding = 0;
		end else begin
			if (s_tvalid && s_tready)
				grant_q.push_back(arbitrate(s_tdata));
			if (m_tvalid && m_tready) begin
				if (grant_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result 0x%02h", m_tdata));
				end else begin
					want = grant_q.pop_front();
					if (m_tdata[0] !== want.granted)
						report_mismatch($sformatf("grant_valid got %b expected %b",
							m_tdata[0], want.granted));
					if (m_tdata[GSLOT_W:1] !== want.slot)
						report_mismatch($sformatf("grant_slot got %0d expected %0d",
							m_tdata[GSLOT_W:1], want.slot));
					if (m_tdata[OUT_W-1:GSLOT_W+1] !== '0)
						report_mismatch($sformatf("pad bits got %b expected zero",
							m_tdata[OUT_W-1:GSLOT_W+1]));
				end
				result_idx++;
			end
			outstanding = grant_q.size();
		end
	end

endmodule

FILE: test/tb_least_served_round_robin_arbiter.sv
// Testbench top for the least-served round-robin arbiter: clock, reset, request
// and result-side stimulus, verdict. Depends on lsrr_pkg, the arbiter RTL and lsrr_grant_checker.
module tb_least_served_round_robin_arbiter;

	import lsrr_pkg::*;

	localparam int N_DIRECTED = 20;
	localparam int N_RANDOM   = 830;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [MASK_W-1:0] s_tdata  = '0;   // [63:0] ready_mask
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;         // [0] grant_valid, [6:1] grant_slot, [7] zero
	int                fail_count;
	int                outstanding;

	// 10-unit period
	always #5 clk = ~clk;

	least_served_round_robin_arbiter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	lsrr_grant_checker u_grant_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// Offer one request. Entered and left at a falling edge; at most one
	// assignment to tvalid per step, so back-to-back requests keep tvalid high.
	// While idling, tdata carries junk so that it is known to be ignored.
	task automatic send_mask(input logic [MASK_W-1:0] mask, input bit may_idle);
		while (may_idle && $urandom_range(99) < 27) begin
			s_tvalid <= 1'b0;
			s_tdata  <= {$urandom, $urandom};
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= mask;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Request side: directed masks, then random ones.
	initial begin : requests
		logic [MASK_W-1:0] directed [N_DIRECTED];
		logic [MASK_W-1:0] m;
		int                n;
		int                hot_base;
		int                roll;
		directed = '{
			64'h0,                    // nothing ready: no grant, pointer to start slot
			64'hFFFF_FFFF_FFFF_FFFF,  // all tied at zero: first met in search order
			64'hFFFF_FFFF_FFFF_FFFF,
			64'h0000_0000_0000_0001,  // lowest slot alone
			64'h8000_0000_0000_0000,  // highest slot alone
			64'h0,                    // idle decision after a grant at the top slot
			64'h8000_0000_0000_0001,  // search wraps past slot 63
			64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA,
			64'hFFFF_FFFF_0000_0000,
			64'h0000_0000_FFFF_FFFF,
			64'h0000_0000_0000_0020,  // build up slot 5
			64'h0000_0000_0000_0020,
			64'h0000_0000_0000_0020,
			64'h0000_0000_0000_0060,  // slot 6 less served than slot 5
			64'h0000_0000_0000_0060,
			64'h0000_0000_0000_0003,  // equal counts across the wrap point
			64'h0,
			64'hFFFF_FFFF_FFFF_FFFF,  // least served wins even far from the pointer
			64'h7FFF_FFFF_FFFF_FFFE
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_mask(directed[i], 1'b1);

		hot_base = $urandom_range(56);
		for (int i = 0; i < N_RANDOM; i++) begin
			// let the block drain completely once, then carry on
			if (i == 420) begin
				s_tvalid <= 1'b0;
				do
					@(negedge clk);
				while (outstanding != 0);
			end
			// a hot group of eight slots shifts now and then, so counts drift apart
			if (i % 100 == 0)
				hot_base = $urandom_range(56);
			roll = $urandom_range(99);
			m    = '0;
			if (roll < 8) begin
				m = '0;
			end else if (roll < 30) begin
				m = {$urandom, $urandom};
			end else if (roll < 50) begin
				m = ($urandom_range(3) == 0) ? '1 : ({$urandom, $urandom} | {$urandom, $urandom});
			end else if (roll < 75) begin
				n = $urandom_range(4, 1);
				repeat (n) m[$urandom_range(63)] = 1'b1;
			end else begin
				m = {$urandom, $urandom} & (64'hFF << hot_base);
			end
			// a long run with no gaps on the request side
			send_mask(m, !(i >= 500 && i < 650));
		end
		s_tvalid <= 1'b0;

		while (outstanding != 0)
			@(negedge clk);
		// one full decision time plus margin for anything stray
		repeat (SLOTS + 40) @(posedge clk);
		if (fail_count == 0)
			$display("[least_served_round_robin_arbiter] OK");
		else
			$display("[least_served_round_robin_arbiter] ERROR");
		$finish;
	end

	// Result side: random back-pressure, one long hold-off after result 300 that
	// lets the block fill and stall its request side, and a no-stall run.
	initial begin : results
		int taken;
		int hold_left;
		taken     = 0;
		hold_left = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (taken >= 500 && taken < 650) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 27);
			end
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				taken++;
				if (taken == 300)
					hold_left = 600;
			end
		end
	end

	// hard stop well past the slowest legal run
	initial begin : watchdog
		#5_000_000;
		$display("[least_served_round_robin_arbiter] ERROR");
		$finish;
	end

endmodule
